[rtl/core/qrm_pkg.sv]
// Shared types and constants for the quaternion to rotation matrix block.
`default_nettype none
package qrm_pkg;

    localparam int DATA_W  = 16;
    localparam int N_W     = 33;  // squared norm, up to 2^32
    localparam int NUM_W   = 34;  // signed numerator, |num| <= n
    localparam int REM_W   = 34;  // divider remainder, below 2n
    localparam int LANES   = 9;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    typedef struct packed {
        logic signed [DATA_W-1:0] quat_x;
        logic signed [DATA_W-1:0] quat_y;
        logic signed [DATA_W-1:0] quat_z;
        logic signed [DATA_W-1:0] quat_w;
    } t_quat_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] col0_row0;
        logic signed [DATA_W-1:0] col0_row1;
        logic signed [DATA_W-1:0] col0_row2;
        logic signed [DATA_W-1:0] col1_row0;
        logic signed [DATA_W-1:0] col1_row1;
        logic signed [DATA_W-1:0] col1_row2;
        logic signed [DATA_W-1:0] col2_row0;
        logic signed [DATA_W-1:0] col2_row1;
        logic signed [DATA_W-1:0] col2_row2;
        logic                     zero_norm;
    } t_mat_out;

    // One classified request: nine numerators, the common divisor, zero flag.
    typedef struct packed {
        logic [LANES-1:0][NUM_W-1:0] num;
        logic [N_W-1:0]              n;
        logic                        zero;
    } t_job;

endpackage
`default_nettype wire

[rtl/core/qrm_front.sv]
// Front end: products, squared norm, numerators and zero-norm classification.
`default_nettype none
module qrm_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire qrm_pkg::t_quat_in      i_quat,
    input  wire logic [qrm_pkg::Q_CW-1:0] i_q_count,
    output logic                        o_push,
    output qrm_pkg::t_job               o_job
);
    logic r_f1_v, r_f2_v;
    logic signed [31:0] r_pxx, r_pyy, r_pzz, r_pww, r_pxy, r_pxz, r_pyz, r_pwx, r_pwy, r_pwz;
    qrm_pkg::t_job r_job;
    logic [qrm_pkg::Q_CW:0] inflight;
    logic accept;
    logic signed [34:0] e_xx, e_yy, e_zz, e_ww, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz, e_n;
    qrm_pkg::t_job n_job;

    // credit check: every request in flight has a queue slot reserved
    assign inflight   = {1'b0, i_q_count} + {{qrm_pkg::Q_CW{1'b0}}, r_f1_v}
                      + {{qrm_pkg::Q_CW{1'b0}}, r_f2_v};
    assign o_in_ready = inflight < (qrm_pkg::Q_CW+1)'(qrm_pkg::Q_DEPTH);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        e_xx = 35'(r_pxx); e_yy = 35'(r_pyy); e_zz = 35'(r_pzz); e_ww = 35'(r_pww);
        e_xy = 35'(r_pxy); e_xz = 35'(r_pxz); e_yz = 35'(r_pyz);
        e_wx = 35'(r_pwx); e_wy = 35'(r_pwy); e_wz = 35'(r_pwz);
        e_n  = e_xx + e_yy + e_zz + e_ww;
        n_job.num[0] = qrm_pkg::NUM_W'(e_n - ((e_yy + e_zz) <<< 1));
        n_job.num[1] = qrm_pkg::NUM_W'((e_xy + e_wz) <<< 1);
        n_job.num[2] = qrm_pkg::NUM_W'((e_xz - e_wy) <<< 1);
        n_job.num[3] = qrm_pkg::NUM_W'((e_xy - e_wz) <<< 1);
        n_job.num[4] = qrm_pkg::NUM_W'(e_n - ((e_xx + e_zz) <<< 1));
        n_job.num[5] = qrm_pkg::NUM_W'((e_yz + e_wx) <<< 1);
        n_job.num[6] = qrm_pkg::NUM_W'((e_xz + e_wy) <<< 1);
        n_job.num[7] = qrm_pkg::NUM_W'((e_yz - e_wx) <<< 1);
        n_job.num[8] = qrm_pkg::NUM_W'(e_n - ((e_xx + e_yy) <<< 1));
        n_job.n      = e_n[qrm_pkg::N_W-1:0];
        n_job.zero   = (e_n == 35'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else begin
            r_f1_v <= accept;
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pxx <= i_quat.quat_x * i_quat.quat_x;
            r_pyy <= i_quat.quat_y * i_quat.quat_y;
            r_pzz <= i_quat.quat_z * i_quat.quat_z;
            r_pww <= i_quat.quat_w * i_quat.quat_w;
            r_pxy <= i_quat.quat_x * i_quat.quat_y;
            r_pxz <= i_quat.quat_x * i_quat.quat_z;
            r_pyz <= i_quat.quat_y * i_quat.quat_z;
            r_pwx <= i_quat.quat_w * i_quat.quat_x;
            r_pwy <= i_quat.quat_w * i_quat.quat_y;
            r_pwz <= i_quat.quat_w * i_quat.quat_z;
        end
        if (r_f1_v) begin
            r_job <= n_job;
        end
    end

    assign o_push = r_f2_v;
    assign o_job  = r_job;
endmodule
`default_nettype wire

[rtl/core/qrm_queue.sv]
// Short request queue between front end and divider back end.
`default_nettype none
module qrm_queue (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire qrm_pkg::t_job            i_job,
    input  wire logic                     i_pop,
    output qrm_pkg::t_job                 o_job,
    output logic                          o_empty,
    output logic [qrm_pkg::Q_CW-1:0]      o_count
);
    qrm_pkg::t_job r_mem [qrm_pkg::Q_DEPTH];
    logic [qrm_pkg::Q_AW-1:0] r_wp, r_rp;
    logic [qrm_pkg::Q_CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {{(qrm_pkg::Q_CW-1){1'b0}}, i_push}
                           - {{(qrm_pkg::Q_CW-1){1'b0}}, i_pop};
        end
    end

    assign o_job   = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != qrm_pkg::Q_CW'(qrm_pkg::Q_DEPTH)))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("queue pop while empty");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != qrm_pkg::Q_CW'(qrm_pkg::Q_DEPTH)) |->
        (qrm_pkg::Q_AW'(r_wp - r_rp) == r_cnt[qrm_pkg::Q_AW-1:0]))
        else $error("queue pointers disagree with count");
`endif
endmodule
`default_nettype wire

[rtl/core/qrm_back.sv]
// Back end: nine-lane pipelined restoring divider, rounding, saturation, output register.
`default_nettype none
module qrm_back #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire qrm_pkg::t_job i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output qrm_pkg::t_mat_out  o_mat
);
    localparam int STG = FRAC_BITS + 1;
    localparam int QW  = STG;
    localparam longint ONE = longint'(1) << FRAC_BITS;
    localparam logic [QW:0] LIM_P = (QW+1)'((ONE > 32767) ? 32767 : ONE);
    localparam logic [QW:0] LIM_N = (QW+1)'((ONE > 32768) ? 32768 : ONE);

    logic b_adv;
    logic                            r_v    [STG];
    logic                            r_z    [STG];
    logic [qrm_pkg::N_W-1:0]         r_n    [STG];
    logic [qrm_pkg::REM_W-1:0]       r_rem  [STG][qrm_pkg::LANES];
    logic [QW-1:0]                   r_q    [STG][qrm_pkg::LANES];
    logic                            r_neg  [STG][qrm_pkg::LANES];
    logic [qrm_pkg::REM_W-1:0]       n_rem  [STG][qrm_pkg::LANES];
    logic [QW-1:0]                   n_q    [STG][qrm_pkg::LANES];
    logic                            n_neg0 [qrm_pkg::LANES];
    logic [qrm_pkg::DATA_W-1:0]      ent    [qrm_pkg::LANES];
    logic                            r_out_v;
    qrm_pkg::t_mat_out               r_out;

    assign b_adv = !r_out_v || i_out_ready;
    assign o_pop = b_adv && !i_empty;

    genvar s, l;
    generate
        for (s = 0; s < STG; s++) begin : g_stg
            for (l = 0; l < qrm_pkg::LANES; l++) begin : g_lane
                logic [qrm_pkg::REM_W-1:0] rem_in;
                logic [QW-1:0]             q_in;
                logic [qrm_pkg::REM_W-1:0] dv;
                logic                      ge;
                always_comb begin
                    if (s == 0) begin
                        // magnitude of the numerator, never above n
                        rem_in = i_job.num[l][qrm_pkg::NUM_W-1] ?
                                 qrm_pkg::REM_W'(-i_job.num[l]) :
                                 qrm_pkg::REM_W'(i_job.num[l]);
                        q_in   = '0;
                        dv     = qrm_pkg::REM_W'(i_job.n);
                    end else begin
                        rem_in = r_rem[(s == 0) ? 0 : s-1][l] << 1;
                        q_in   = r_q[(s == 0) ? 0 : s-1][l];
                        dv     = qrm_pkg::REM_W'(r_n[(s == 0) ? 0 : s-1]);
                    end
                    ge          = rem_in >= dv;
                    n_rem[s][l] = ge ? rem_in - dv : rem_in;
                    n_q[s][l]   = q_in | (QW'(ge) << (STG-1-s));
                end
                always_ff @(posedge i_clk) begin
                    if (b_adv) begin
                        r_rem[s][l] <= n_rem[s][l];
                        r_q[s][l]   <= n_q[s][l];
                        r_neg[s][l] <= (s == 0) ? n_neg0[l] : r_neg[(s == 0) ? 0 : s-1][l];
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                if (b_adv) begin
                    r_n[s] <= (s == 0) ? i_job.n    : r_n[(s == 0) ? 0 : s-1];
                    r_z[s] <= (s == 0) ? i_job.zero : r_z[(s == 0) ? 0 : s-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (b_adv) begin
                    r_v[s] <= (s == 0) ? o_pop : r_v[(s == 0) ? 0 : s-1];
                end
            end
        end

        for (l = 0; l < qrm_pkg::LANES; l++) begin : g_fin
            logic [qrm_pkg::REM_W:0] rsum;
            logic [QW:0]             qf;
            logic [QW:0]             qc;
            always_comb begin
                n_neg0[l] = i_job.num[l][qrm_pkg::NUM_W-1];
                // round half away from zero: remainder plus n/2 reaching n
                rsum = (qrm_pkg::REM_W+1)'(r_rem[STG-1][l])
                     + (qrm_pkg::REM_W+1)'(r_n[STG-1] >> 1);
                qf   = (QW+1)'(r_q[STG-1][l])
                     + (QW+1)'(rsum >= (qrm_pkg::REM_W+1)'(r_n[STG-1]));
                if (r_neg[STG-1][l]) begin
                    qc     = (qf > LIM_N) ? LIM_N : qf;
                    ent[l] = qrm_pkg::DATA_W'(16'd0 - qrm_pkg::DATA_W'(qc));
                end else begin
                    qc     = (qf > LIM_P) ? LIM_P : qf;
                    ent[l] = qrm_pkg::DATA_W'(qc);
                end
                if (r_z[STG-1]) begin
                    ent[l] = (l % 4 == 0) ? qrm_pkg::DATA_W'(LIM_P) : '0;
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (b_adv) begin
            r_out_v <= r_v[STG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv && r_v[STG-1]) begin
            r_out.col0_row0 <= ent[0];
            r_out.col0_row1 <= ent[1];
            r_out.col0_row2 <= ent[2];
            r_out.col1_row0 <= ent[3];
            r_out.col1_row1 <= ent[4];
            r_out.col1_row2 <= ent[5];
            r_out.col2_row0 <= ent[6];
            r_out.col2_row1 <= ent[7];
            r_out.col2_row2 <= ent[8];
            r_out.zero_norm <= r_z[STG-1];
        end
    end

    assign o_out_valid = r_out_v;
    assign o_mat       = r_out;
endmodule
`default_nettype wire

[rtl/core/quaternion_to_rotation_matrix.sv]
// Pipeline from input request to result: 2 front-end registers, 1 queue register,
//   FRAC_BITS + 1 divider stages and 1 output register.
// Throughput: one quaternion per cycle unless the output stalls; the nine lanes of the
//   pipelined restoring divider each resolve one quotient bit per stage.
// A 4-entry queue decouples front end and divider; output stall freezes the divider.
// Reset: synchronous active-low i_rst_n clears valids, queue pointers and queue count only.
`default_nettype none
module quaternion_to_rotation_matrix #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire qrm_pkg::t_quat_in i_quat,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output qrm_pkg::t_mat_out      o_mat
);
    logic                        push, pop, empty;
    qrm_pkg::t_job               f_job, q_job;
    logic [qrm_pkg::Q_CW-1:0]    q_count;

    qrm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_quat     (i_quat),
        .i_q_count  (q_count),
        .o_push     (push),
        .o_job      (f_job)
    );

    qrm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_empty (empty),
        .o_count (q_count)
    );

    qrm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_mat       (o_mat)
    );
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Testbench for quaternion_to_rotation_matrix: directed and random quaternions checked against a predictor.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 14;
    localparam int N_RANDOM = 1250;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    qrm_pkg::t_quat_in i_quat = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    qrm_pkg::t_mat_out o_mat;

    quaternion_to_rotation_matrix #(.FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_quat(i_quat),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_mat(o_mat)
    );

    always #4 i_clk = ~i_clk;

    qrm_pkg::t_quat_in pending_quats[$];
    qrm_pkg::t_mat_out expected_mats[$];
    int       fail_cnt = 0;
    int       idle_cycles = 0;
    bit       stimulus_done = 0;
    bit       hold_sink = 0;     // long receiver hold-off
    bit       sender_pause = 0;  // sender waits for empty pipe
    bit       in_taken = 0;      // request accepted at the last rising edge

    function automatic logic signed [15:0] clamp_entry(longint v);
        longint one;
        one = longint'(1) << FRAC;
        if (v > one) v = one;
        if (v < -one) v = -one;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    // num * 2^FRAC / n, round half away from zero
    function automatic longint round_div(longint num, longint n);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = ((mag <<< FRAC) + (n >>> 1)) / n;
        return (num < 0) ? -q : q;
    endfunction

    function automatic qrm_pkg::t_mat_out rotation_of(qrm_pkg::t_quat_in q);
        qrm_pkg::t_mat_out m;
        longint x, y, z, w, n;
        longint num[9];
        logic signed [15:0] e[9];
        x = q.quat_x; y = q.quat_y; z = q.quat_z; w = q.quat_w;
        n = x*x + y*y + z*z + w*w;
        if (n == 0) begin
            for (int i = 0; i < 9; i++)
                e[i] = clamp_entry((i % 4 == 0) ? (longint'(1) << FRAC) : 0);
        end else begin
            num[0] = n - 2*(y*y + z*z);
            num[1] = 2*(x*y + w*z);
            num[2] = 2*(x*z - w*y);
            num[3] = 2*(x*y - w*z);
            num[4] = n - 2*(x*x + z*z);
            num[5] = 2*(y*z + w*x);
            num[6] = 2*(x*z + w*y);
            num[7] = 2*(y*z - w*x);
            num[8] = n - 2*(x*x + y*y);
            for (int i = 0; i < 9; i++) e[i] = clamp_entry(round_div(num[i], n));
        end
        m.col0_row0 = e[0]; m.col0_row1 = e[1]; m.col0_row2 = e[2];
        m.col1_row0 = e[3]; m.col1_row1 = e[4]; m.col1_row2 = e[5];
        m.col2_row0 = e[6]; m.col2_row1 = e[7]; m.col2_row2 = e[8];
        m.zero_norm = (n == 0);
        return m;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_comp();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 7)) - 16'd3;
            3: return 16'h4000;
            default: return 16'($urandom);
        endcase
    endfunction

    // driver
    int src_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !in_taken) begin
                // hold request
            end else begin
                if (i_in_valid) void'(pending_quats.pop_front());
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_quats.size() > 0 && !sender_pause) begin
                    i_quat <= pending_quats[0];
                    i_in_valid <= 1'b1;
                    src_gap <= gap_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // prediction at the accepting edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready)
                expected_mats.push_back(rotation_of(i_quat));
        end
    end

    // receiver ready
    int sink_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_sink) begin
                i_out_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                sink_gap <= gap_len();
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        qrm_pkg::t_mat_out exp_m;
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_out_valid && i_out_ready) begin
                if (expected_mats.size() == 0) begin
                    $error("unexpected result %p", o_mat);
                    fail_cnt++;
                end else begin
                    exp_m = expected_mats.pop_front();
                    if (o_mat.col0_row0 !== exp_m.col0_row0) begin
                        $error("col0_row0 exp %0d got %0d", exp_m.col0_row0, o_mat.col0_row0);
                        fail_cnt++;
                    end
                    if (o_mat.col0_row1 !== exp_m.col0_row1) begin
                        $error("col0_row1 exp %0d got %0d", exp_m.col0_row1, o_mat.col0_row1);
                        fail_cnt++;
                    end
                    if (o_mat.col0_row2 !== exp_m.col0_row2) begin
                        $error("col0_row2 exp %0d got %0d", exp_m.col0_row2, o_mat.col0_row2);
                        fail_cnt++;
                    end
                    if (o_mat.col1_row0 !== exp_m.col1_row0) begin
                        $error("col1_row0 exp %0d got %0d", exp_m.col1_row0, o_mat.col1_row0);
                        fail_cnt++;
                    end
                    if (o_mat.col1_row1 !== exp_m.col1_row1) begin
                        $error("col1_row1 exp %0d got %0d", exp_m.col1_row1, o_mat.col1_row1);
                        fail_cnt++;
                    end
                    if (o_mat.col1_row2 !== exp_m.col1_row2) begin
                        $error("col1_row2 exp %0d got %0d", exp_m.col1_row2, o_mat.col1_row2);
                        fail_cnt++;
                    end
                    if (o_mat.col2_row0 !== exp_m.col2_row0) begin
                        $error("col2_row0 exp %0d got %0d", exp_m.col2_row0, o_mat.col2_row0);
                        fail_cnt++;
                    end
                    if (o_mat.col2_row1 !== exp_m.col2_row1) begin
                        $error("col2_row1 exp %0d got %0d", exp_m.col2_row1, o_mat.col2_row1);
                        fail_cnt++;
                    end
                    if (o_mat.col2_row2 !== exp_m.col2_row2) begin
                        $error("col2_row2 exp %0d got %0d", exp_m.col2_row2, o_mat.col2_row2);
                        fail_cnt++;
                    end
                    if (o_mat.zero_norm !== exp_m.zero_norm) begin
                        $error("zero_norm exp %0d got %0d", exp_m.zero_norm, o_mat.zero_norm);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    function automatic qrm_pkg::t_quat_in mk(logic [15:0] x, logic [15:0] y,
                                             logic [15:0] z, logic [15:0] w);
        qrm_pkg::t_quat_in q;
        q.quat_x = x; q.quat_y = y; q.quat_z = z; q.quat_w = w;
        return q;
    endfunction

    // watchdog
    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** quaternion_to_rotation_matrix: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        qrm_pkg::t_quat_in q;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero, unit axes, extremes, one-bit values
        pending_quats.push_back(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        pending_quats.push_back(mk(16'h0000, 16'h0000, 16'h0000, 16'h4000));
        pending_quats.push_back(mk(16'h4000, 16'h0000, 16'h0000, 16'h0000));
        pending_quats.push_back(mk(16'h0000, 16'h4000, 16'h0000, 16'h0000));
        pending_quats.push_back(mk(16'h0000, 16'h0000, 16'h4000, 16'h0000));
        pending_quats.push_back(mk(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        pending_quats.push_back(mk(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
        pending_quats.push_back(mk(16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
        pending_quats.push_back(mk(16'h0001, 16'h0000, 16'h0000, 16'h0000));
        pending_quats.push_back(mk(16'hffff, 16'h0001, 16'hffff, 16'h0001));
        pending_quats.push_back(mk(16'h0000, 16'h0000, 16'h0000, 16'hc000));
        pending_quats.push_back(mk(16'h2d41, 16'h0000, 16'h0000, 16'h2d41));
        pending_quats.push_back(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        pending_quats.push_back(mk(16'h0001, 16'h0001, 16'h0001, 16'h0001));
        pending_quats.push_back(mk(16'haaaa, 16'h5555, 16'haaaa, 16'h5555));

        // receiver holds off while the sender keeps offering
        hold_sink = 1;
        for (int i = 0; i < 30; i++)
            pending_quats.push_back(mk(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
        repeat (120) @(posedge i_clk);
        hold_sink = 0;

        for (int i = 0; i < N_RANDOM; i++) begin
            q = mk(rand_comp(), rand_comp(), rand_comp(), rand_comp());
            if ($urandom_range(0, 60) == 0) q = '0;  // occasional zero among random
            pending_quats.push_back(q);
            if (i == N_RANDOM / 2) begin
                wait (pending_quats.size() == 0 && !i_in_valid);
                sender_pause = 1;
                wait (expected_mats.size() == 0);
                sender_pause = 0;
            end
        end

        wait (pending_quats.size() == 0 && !i_in_valid);
        wait (expected_mats.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && expected_mats.size() == 0)
            $display("** quaternion_to_rotation_matrix: PASSED **");
        else
            $display("** quaternion_to_rotation_matrix: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
rtl/core/qrm_pkg.sv
rtl/core/qrm_front.sv
rtl/core/qrm_queue.sv
rtl/core/qrm_back.sv
rtl/core/quaternion_to_rotation_matrix.sv
tb/tb_top.sv
